// ===== hw/rtl/mfs_pkg.sv =====
// Shared types, constants and helpers for the marker-framed field splitter.
// Used by mfs_parser, mfs_result_queue and marker_framed_field_splitter_unit.
`timescale 1ns / 1ps

package mfs_pkg;

  // Marker and field limits
  localparam int MARKER_BYTES = 4;
  localparam int MAX_FIELDS   = 16;
  localparam int MARKER_W     = MARKER_BYTES * 8;
  localparam int COUNT_W      = $clog2(MARKER_BYTES + 1);
  localparam int FIELD_CNT_W  = $clog2(MAX_FIELDS + 1);

  // Fixed field widths of the ports
  localparam int LEN_W        = 3;
  localparam int FIELD_NUM_W  = 4;
  localparam int TOTAL_W      = 5;
  localparam int TICK_W       = 16;

  // Result queue
  localparam int QUEUE_DEPTH  = 4;
  localparam int QCOUNT_W     = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int PADDR_W      = 5;
  localparam int PDATA_W      = 32;

  // Register reset values
  localparam logic [31:0]       START_MARKER_RST  = 32'd0;
  localparam logic [LEN_W-1:0]  START_LENGTH_RST  = 3'd1;
  localparam logic [31:0]       END_MARKER_RST    = 32'd0;
  localparam logic [LEN_W-1:0]  END_LENGTH_RST    = 3'd1;
  localparam logic [7:0]        SEPARATOR_RST     = 8'd44;
  localparam logic [TICK_W-1:0] IDLE_LIMIT_RST    = 16'd100;
  localparam logic [TICK_W-1:0] FLUSH_PERIOD_RST  = 16'd2500;
  localparam logic [TICK_W-1:0] TICK_MAX          = {TICK_W{1'b1}};

  // Register indexes (byte address = 4 * index)
  typedef enum logic [2:0] {
    REG_START_MARKER = 3'd0,
    REG_START_LENGTH = 3'd1,
    REG_END_MARKER   = 3'd2,
    REG_END_LENGTH   = 3'd3,
    REG_SEPARATOR    = 3'd4,
    REG_IDLE_LIMIT   = 3'd5,
    REG_FLUSH_PERIOD = 3'd6,
    REG_NONE         = 3'd7
  } reg_idx_t;

  // Input operation codes
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_FIELD_END = 2'd1,
    KIND_FRAME_END = 2'd2,
    KIND_ABORT     = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [FIELD_NUM_W-1:0] field_number;
    logic [7:0]             out_byte;
    logic [TOTAL_W-1:0]     fields_total;
    logic                   last;
  } result_t;

  // Up to two results per accepted transaction
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } step_t;

  typedef struct packed {
    logic [31:0]       start_marker;
    logic [LEN_W-1:0]  start_length;
    logic [31:0]       end_marker;
    logic [LEN_W-1:0]  end_length;
    logic [7:0]        separator_byte;
    logic [TICK_W-1:0] idle_limit;
    logic [TICK_W-1:0] flush_period;
  } cfg_t;

  // Lengths above the marker size act as the full marker
  function automatic logic [COUNT_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
    logic [COUNT_W-1:0] r;
    if (int'(n) > MARKER_BYTES) r = COUNT_W'(MARKER_BYTES);
    else                        r = COUNT_W'(n);
    return r;
  endfunction

  // Mask covering the low n bytes of the marker window
  function automatic logic [MARKER_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
    logic [MARKER_W-1:0] m;
    m = '0;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (i < int'(n)) m[8*i +: 8] = 8'hFF;
    end
    return m;
  endfunction

  function automatic result_t mk_result(input kind_t k, input logic [FIELD_CNT_W-1:0] fld,
                                        input logic [7:0] b,
                                        input logic [FIELD_CNT_W-1:0] tot);
    result_t r;
    r.kind         = k;
    r.field_number = FIELD_NUM_W'(fld);
    r.out_byte     = b;
    r.fields_total = TOTAL_W'(tot);
    r.last         = 1'b0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/mfs_parser.sv =====
// Frame parser: hunting, body delay line, field split, idle and flush timers.
// Depends on mfs_pkg; emits up to two results per accepted transaction.
`timescale 1ns / 1ps

module mfs_parser
  import mfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic       op,
  input  logic [7:0] rx_byte,
  input  cfg_t       cfg,
  output step_t      step
);

  logic                   in_frame_r, in_frame_nxt;
  logic [MARKER_W-1:0]    recent_r, recent_nxt;
  logic [COUNT_W-1:0]     count_r, count_nxt;
  logic [FIELD_CNT_W-1:0] field_r, field_nxt;
  logic [TICK_W-1:0]      idle_r, idle_nxt;
  logic [TICK_W-1:0]      flush_r, flush_nxt;

  logic [COUNT_W-1:0]     sl, el, hold, cnt_inc;
  logic [MARKER_W-1:0]    cand;
  logic [7:0]             old_byte;
  logic                   start_hit, end_hit;

  // Shifted window and the byte that leaves the delay line
  always_comb begin
    sl       = clamp_len(cfg.start_length);
    el       = clamp_len(cfg.end_length);
    hold     = (el == '0) ? '0 : el - COUNT_W'(1);
    cand     = (recent_r << 8) | MARKER_W'(rx_byte);
    cnt_inc  = count_r + COUNT_W'(1);
    old_byte = '0;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (int'(count_r) == i) old_byte = cand[8*i +: 8];
    end
  end

  // Next state and results
  always_comb begin
    in_frame_nxt = in_frame_r;
    recent_nxt   = recent_r;
    count_nxt    = count_r;
    field_nxt    = field_r;
    idle_nxt     = idle_r;
    flush_nxt    = flush_r;
    start_hit    = 1'b0;
    end_hit      = 1'b0;
    step.count   = 2'd0;
    step.res0    = mk_result(KIND_DATA, '0, '0, '0);
    step.res1    = mk_result(KIND_DATA, '0, '0, '0);

    if (op == OP_TICK) begin
      idle_nxt  = (idle_r  != TICK_MAX) ? idle_r  + TICK_W'(1) : idle_r;
      flush_nxt = (flush_r != TICK_MAX) ? flush_r + TICK_W'(1) : flush_r;
      if (flush_nxt > cfg.flush_period) begin
        // flush: drop everything, report only if a frame was open
        if (in_frame_r) begin
          step.count = 2'd1;
          step.res0  = mk_result(KIND_ABORT, '0, '0, '0);
        end
        in_frame_nxt = 1'b0;
        field_nxt    = '0;
        recent_nxt   = '0;
        count_nxt    = '0;
        flush_nxt    = '0;
      end else if (in_frame_r && el == '0 && idle_nxt > cfg.idle_limit) begin
        end_hit = 1'b1;
      end
    end else begin
      idle_nxt = '0;
      if (!in_frame_r) begin
        // hunting for the start marker
        recent_nxt = cand;
        count_nxt  = (int'(count_r) < MARKER_BYTES) ? cnt_inc : count_r;
        start_hit  = (sl == '0) ||
                     (count_nxt >= sl &&
                      (cand & byte_mask(sl)) == (MARKER_W'(cfg.start_marker) & byte_mask(sl)));
        if (start_hit) begin
          in_frame_nxt = 1'b1;
          field_nxt    = '0;
          recent_nxt   = '0;
          count_nxt    = '0;
        end
      end else if (el != '0 && cnt_inc >= el &&
                   (cand & byte_mask(el)) == (MARKER_W'(cfg.end_marker) & byte_mask(el))) begin
        end_hit = 1'b1;
      end else if (count_r >= hold) begin
        // oldest held byte leaves the delay line
        recent_nxt = cand & byte_mask(count_r);
        if (int'(field_r) < MAX_FIELDS) begin
          step.count = 2'd1;
          if (old_byte == cfg.separator_byte) begin
            step.res0 = mk_result(KIND_FIELD_END, field_r, '0, '0);
            field_nxt = field_r + FIELD_CNT_W'(1);
          end else begin
            step.res0 = mk_result(KIND_DATA, field_r, old_byte, '0);
          end
        end
      end else begin
        recent_nxt = cand;
        count_nxt  = cnt_inc;
      end
    end

    // frame end: close the open field if room, then report the count
    if (end_hit) begin
      if (int'(field_r) < MAX_FIELDS) begin
        step.count = 2'd2;
        step.res0  = mk_result(KIND_FIELD_END, field_r, '0, '0);
        step.res1  = mk_result(KIND_FRAME_END, '0, '0, field_r + FIELD_CNT_W'(1));
      end else begin
        step.count = 2'd1;
        step.res0  = mk_result(KIND_FRAME_END, '0, '0, field_r);
      end
      in_frame_nxt = 1'b0;
      field_nxt    = '0;
      recent_nxt   = '0;
      count_nxt    = '0;
    end

    if (step.count == 2'd1) step.res0.last = 1'b1;
    if (step.count == 2'd2) step.res1.last = 1'b1;
  end

  // State registers, updated per accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      recent_r   <= '0;
      count_r    <= '0;
      field_r    <= '0;
      idle_r     <= '0;
      flush_r    <= '0;
    end else if (accept) begin
      in_frame_r <= in_frame_nxt;
      recent_r   <= recent_nxt;
      count_r    <= count_nxt;
      field_r    <= field_nxt;
      idle_r     <= idle_nxt;
      flush_r    <= flush_nxt;
    end
  end

endmodule

// ===== hw/rtl/mfs_result_queue.sv =====
// Result queue: shifting register queue, two pushes and one pop per cycle.
// Depends on mfs_pkg; the head entry drives the result channel directly.
`timescale 1ns / 1ps

module mfs_result_queue
  import mfs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  step_t               step,
  input  logic                pop,
  output result_t             head,
  output logic [QCOUNT_W-1:0] count
);

  result_t             q_r   [QUEUE_DEPTH];
  result_t             q_nxt [QUEUE_DEPTH];
  logic [QCOUNT_W-1:0] count_r, count_nxt, base;
  logic [1:0]          n_push;

  // Entry selection: shift on pop, append new results behind survivors
  always_comb begin
    n_push    = push ? step.count : 2'd0;
    base      = count_r - QCOUNT_W'(pop);
    count_nxt = base + QCOUNT_W'(n_push);
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (i < int'(base)) begin
        if (pop && i + 1 < QUEUE_DEPTH) q_nxt[i] = q_r[(i + 1) % QUEUE_DEPTH];
      end else if (i == int'(base) && n_push != 2'd0) begin
        q_nxt[i] = step.res0;
      end else if (i == int'(base) + 1 && n_push == 2'd2) begin
        q_nxt[i] = step.res1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = q_r[0];
  assign count = count_r;

endmodule

// ===== hw/rtl/marker_framed_field_splitter_unit.sv =====
// Top level of the marker-framed field splitter: config registers, parser, result queue.
// Depends on mfs_pkg, mfs_parser and mfs_result_queue.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in_     | input     | in_valid / in_stall    | in_operation, in_rx_byte
//   out_    | output    | out_valid / out_stall  | out_kind, out_field_number, out_byte,
//           |           |                        | out_fields_total, out_last
//   config  | input     | APB, pready always 1   | paddr, pwdata, prdata
//
// A transaction is parsed in the cycle it is accepted; its zero to two results enter a
// four-entry queue whose registered head entry drives the out_ ports directly.
// One input transaction per cycle is taken while the queue holds two entries or fewer,
// so the rate is one per cycle as long as results drain; input is held off only by the queue.
// Reset (rst_n low, synchronous) restores register defaults, clears the parser state and
// empties the queue. A stall on the output side just holds the head entry.
`timescale 1ns / 1ps

module marker_framed_field_splitter_unit
  import mfs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_operation,
  input  logic [7:0]             in_rx_byte,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_kind,
  output logic [FIELD_NUM_W-1:0] out_field_number,
  output logic [7:0]             out_byte,
  output logic [TOTAL_W-1:0]     out_fields_total,
  output logic                   out_last,
  // configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready
);

  cfg_t                cfg_r;
  reg_idx_t            reg_idx;
  logic                wr_en, in_accept, pop;
  step_t               step;
  result_t             head;
  logic [QCOUNT_W-1:0] q_count;

  // Configuration registers
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker   <= START_MARKER_RST;
      cfg_r.start_length   <= START_LENGTH_RST;
      cfg_r.end_marker     <= END_MARKER_RST;
      cfg_r.end_length     <= END_LENGTH_RST;
      cfg_r.separator_byte <= SEPARATOR_RST;
      cfg_r.idle_limit     <= IDLE_LIMIT_RST;
      cfg_r.flush_period   <= FLUSH_PERIOD_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_START_MARKER: cfg_r.start_marker   <= pwdata;
        REG_START_LENGTH: cfg_r.start_length   <= pwdata[LEN_W-1:0];
        REG_END_MARKER:   cfg_r.end_marker     <= pwdata;
        REG_END_LENGTH:   cfg_r.end_length     <= pwdata[LEN_W-1:0];
        REG_SEPARATOR:    cfg_r.separator_byte <= pwdata[7:0];
        REG_IDLE_LIMIT:   cfg_r.idle_limit     <= pwdata[TICK_W-1:0];
        REG_FLUSH_PERIOD: cfg_r.flush_period   <= pwdata[TICK_W-1:0];
        REG_NONE:         ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_START_MARKER: prdata = cfg_r.start_marker;
      REG_START_LENGTH: prdata = PDATA_W'(cfg_r.start_length);
      REG_END_MARKER:   prdata = cfg_r.end_marker;
      REG_END_LENGTH:   prdata = PDATA_W'(cfg_r.end_length);
      REG_SEPARATOR:    prdata = PDATA_W'(cfg_r.separator_byte);
      REG_IDLE_LIMIT:   prdata = PDATA_W'(cfg_r.idle_limit);
      REG_FLUSH_PERIOD: prdata = PDATA_W'(cfg_r.flush_period);
      REG_NONE:         prdata = '0;
    endcase
  end

  // Handshakes: hold input off unless the queue has room for two results
  assign in_stall  = (int'(q_count) > QUEUE_DEPTH - 2);
  assign in_accept = in_valid & ~in_stall;
  assign out_valid = (q_count != '0);
  assign pop       = out_valid & ~out_stall;

  mfs_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (in_accept),
    .op      (in_operation),
    .rx_byte (in_rx_byte),
    .cfg     (cfg_r),
    .step    (step)
  );

  mfs_result_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_accept),
    .step  (step),
    .pop   (pop),
    .head  (head),
    .count (q_count)
  );

  // Result payload from the queue head
  assign out_kind         = head.kind;
  assign out_field_number = head.field_number;
  assign out_byte         = head.out_byte;
  assign out_fields_total = head.fields_total;
  assign out_last         = head.last;

endmodule

// ===== tb/sv/marker_framed_field_splitter_unit_tb.sv =====
// Self-checking testbench for marker_framed_field_splitter_unit: byte/tick stimulus,
// APB register setup and a scoreboard that predicts the data, field and frame stream.
// Depends on mfs_pkg and the marker_framed_field_splitter_unit RTL.
`timescale 1ns / 1ps

module marker_framed_field_splitter_unit_tb;
  import mfs_pkg::*;

  localparam int CLK_HALF  = 5;
  localparam int LIMIT     = 200000;
  localparam int MAX_FLD   = 16;
  localparam int WIN_BYTES = 4;

  // Predicts the result stream from the accepted transactions and checks it
  class field_stream_tracker;
    logic [31:0] start_marker, end_marker;
    logic [2:0]  start_length, end_length;
    logic [7:0]  separator;
    logic [15:0] idle_limit, flush_period;
    bit          in_frame;
    logic [31:0] history;
    int unsigned history_cnt, fields_done, idle_ticks, flush_ticks;
    result_t     step_out[$];
    result_t     expected_results[$];
    int unsigned mismatches;

    function new();
      start_marker = 32'd0;
      start_length = 3'd1;
      end_marker   = 32'd0;
      end_length   = 3'd1;
      separator    = 8'd44;
      idle_limit   = 16'd100;
      flush_period = 16'd2500;
      in_frame     = 1'b0;
      history      = '0;
      history_cnt  = 0;
      fields_done  = 0;
      idle_ticks   = 0;
      flush_ticks  = 0;
      mismatches   = 0;
    endfunction

    function int unsigned eff_len(logic [2:0] n);
      return (n > 3'(WIN_BYTES)) ? WIN_BYTES : int'(n);
    endfunction

    function logic [31:0] low_bytes(int unsigned n);
      logic [31:0] m;
      m = '0;
      for (int i = 0; i < WIN_BYTES; i++) begin
        if (i < n) m[8*i +: 8] = 8'hFF;
      end
      return m;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void set_reg(reg_idx_t idx, logic [31:0] val);
      case (idx)
        REG_START_MARKER: start_marker = val;
        REG_START_LENGTH: start_length = val[2:0];
        REG_END_MARKER:   end_marker   = val;
        REG_END_LENGTH:   end_length   = val[2:0];
        REG_SEPARATOR:    separator    = val[7:0];
        REG_IDLE_LIMIT:   idle_limit   = val[15:0];
        REG_FLUSH_PERIOD: flush_period = val[15:0];
        default: ;
      endcase
    endfunction

    function void push(kind_t k, int unsigned fld, logic [7:0] d, int unsigned total);
      result_t r;
      r.kind         = k;
      r.field_number = 4'(fld);
      r.out_byte     = d;
      r.fields_total = 5'(total);
      r.last         = 1'b0;
      step_out.push_back(r);
    endfunction

    function void clear_history();
      history     = '0;
      history_cnt = 0;
    endfunction

    // Open field gets its end unless the field budget is used up
    function void close_frame();
      if (fields_done < MAX_FLD) begin
        push(KIND_FIELD_END, fields_done, 8'd0, 0);
        fields_done++;
      end
      push(KIND_FRAME_END, 0, 8'd0, fields_done);
      in_frame    = 1'b0;
      fields_done = 0;
      clear_history();
    endfunction

    function void emit_body(logic [7:0] d);
      if (fields_done >= MAX_FLD) return;
      if (d == separator) begin
        push(KIND_FIELD_END, fields_done, 8'd0, 0);
        fields_done++;
      end else begin
        push(KIND_DATA, fields_done, d, 0);
      end
    endfunction

    // One accepted input transaction
    function void take_item(op_t op, logic [7:0] d);
      int unsigned el, sl, hold, c;
      logic [31:0] cand;
      step_out.delete();
      el = eff_len(end_length);
      if (op == OP_TICK) begin
        if (idle_ticks < 16'hFFFF) idle_ticks++;
        if (flush_ticks < 16'hFFFF) flush_ticks++;
        // flush wins over the idle end
        if (flush_ticks > flush_period) begin
          if (in_frame) push(KIND_ABORT, 0, 8'd0, 0);
          in_frame    = 1'b0;
          fields_done = 0;
          clear_history();
          flush_ticks = 0;
        end
        if (in_frame && el == 0 && idle_ticks > idle_limit) close_frame();
      end else begin
        idle_ticks = 0;
        if (!in_frame) begin
          // hunting for the start marker
          sl = eff_len(start_length);
          history = {history[23:0], d};
          if (history_cnt < WIN_BYTES) history_cnt++;
          if (sl == 0 || (history_cnt >= sl &&
              (history & low_bytes(sl)) == (start_marker & low_bytes(sl)))) begin
            in_frame    = 1'b1;
            fields_done = 0;
            clear_history();
          end
        end else begin
          // body bytes go through the end-marker delay line
          hold = (el == 0) ? 0 : el - 1;
          c    = history_cnt + 1;
          cand = {history[23:0], d};
          if (el != 0 && c >= el &&
              (cand & low_bytes(el)) == (end_marker & low_bytes(el))) begin
            close_frame();
          end else if (history_cnt >= hold) begin
            emit_body(cand[8*(c-1) +: 8]);
            history     = cand & low_bytes(c - 1);
            history_cnt = c - 1;
          end else begin
            history     = cand;
            history_cnt = c;
          end
        end
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) expected_results.push_back(step_out[i]);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d field %0d byte %02h total %0d last %0b",
                   got.kind, got.field_number, got.out_byte, got.fields_total, got.last);
        return;
      end
      want = expected_results.pop_front();
      if (got.kind !== want.kind || got.field_number !== want.field_number ||
          got.out_byte !== want.out_byte || got.fields_total !== want.fields_total ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("result mismatch: expected kind %0d field %0d byte %02h total %0d last %0b",
                   want.kind, want.field_number, want.out_byte, want.fields_total,
                   want.last);
          $display("                 got      kind %0d field %0d byte %02h total %0d last %0b",
                   got.kind, got.field_number, got.out_byte, got.fields_total, got.last);
        end
      end
    endfunction
  endclass

  logic                   clk          = 1'b0;
  logic                   rst_n        = 1'b0;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  logic                   in_operation = 1'b0;
  logic [7:0]             in_rx_byte   = 8'd0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic [1:0]             out_kind;
  logic [FIELD_NUM_W-1:0] out_field_number;
  logic [7:0]             out_byte;
  logic [TOTAL_W-1:0]     out_fields_total;
  logic                   out_last;
  logic                   psel         = 1'b0;
  logic                   penable      = 1'b0;
  logic                   pwrite       = 1'b0;
  logic [PADDR_W-1:0]     paddr        = '0;
  logic [PDATA_W-1:0]     pwdata       = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;

  field_stream_tracker tracker = new();
  int unsigned cycles         = 0;
  int unsigned items_sent     = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  marker_framed_field_splitter_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_operation     (in_operation),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_field_number (out_field_number),
    .out_byte         (out_byte),
    .out_fields_total (out_fields_total),
    .out_last         (out_last),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #CLK_HALF clk = ~clk;

  // Receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.kind         = kind_t'(out_kind);
      got.field_number = out_field_number;
      got.out_byte     = out_byte;
      got.fields_total = out_fields_total;
      got.last         = out_last;
      tracker.check_result(got);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One input transaction; in_stall is sampled mid-cycle where it is settled
  task automatic send_item(op_t op, logic [7:0] d);
    logic stalled;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_rx_byte   <= d;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    tracker.take_item(op, d);
    items_sent++;
  endtask

  task automatic send_byte(logic [7:0] d);
    send_item(OP_BYTE, d);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 8'($urandom));
  endtask

  task automatic send_noise();
    if ($urandom_range(0, 1) == 1) send_tick();
    else send_byte(8'($urandom));
  endtask

  // APB write: setup, then access until pready
  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    logic ready;
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      ready = pready;
      @(posedge clk);
    end while (!ready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic set_cfg(logic [31:0] sm, logic [31:0] sl, logic [31:0] em,
                         logic [31:0] el, logic [31:0] sep, logic [31:0] idl,
                         logic [31:0] fl);
    write_reg(REG_START_MARKER, sm);
    write_reg(REG_START_LENGTH, sl);
    write_reg(REG_END_MARKER, em);
    write_reg(REG_END_LENGTH, el);
    write_reg(REG_SEPARATOR, sep);
    write_reg(REG_IDLE_LIMIT, idl);
    write_reg(REG_FLUSH_PERIOD, fl);
  endtask

  // Sender holds off until every predicted result is out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Body bytes are mostly random, sometimes pieces of the end marker
  function automatic logic [7:0] body_byte();
    int unsigned pos;
    pos = $urandom_range(0, 3);
    if ($urandom_range(0, 9) == 0) return tracker.end_marker[8*pos +: 8];
    return 8'($urandom);
  endfunction

  // One frame under the current settings, sometimes noisy or broken
  task automatic send_frame();
    int unsigned sl, el, nf, flen, nticks;
    bit big;
    sl = tracker.eff_len(tracker.start_length);
    el = tracker.eff_len(tracker.end_length);
    if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 4)) send_noise();
    if (sl == 0) begin
      send_byte(8'($urandom));
    end else begin
      for (int i = int'(sl) - 1; i >= 0; i--) begin
        if (i == 0 && $urandom_range(0, 99) < 8)
          send_byte(tracker.start_marker[8*i +: 8] ^ 8'h01);
        else
          send_byte(tracker.start_marker[8*i +: 8]);
      end
    end
    // mostly short frames, a few run past the field limit
    big = ($urandom_range(0, 99) < 12);
    nf  = big ? $urandom_range(16, 18) : $urandom_range(1, 4);
    for (int f = 0; f < nf; f++) begin
      flen = big ? $urandom_range(0, 1) : $urandom_range(0, 3);
      repeat (flen) send_byte(body_byte());
      if ($urandom_range(0, 99) < 20) send_tick();
      if (f != nf - 1) send_byte(tracker.separator);
    end
    if (el != 0) begin
      if ($urandom_range(0, 99) < 90) begin
        for (int i = int'(el) - 1; i >= 0; i--) send_byte(tracker.end_marker[8*i +: 8]);
      end
    end else begin
      nticks = (tracker.idle_limit <= 16'd8) ? tracker.idle_limit + 1 : 2;
      repeat (nticks) send_tick();
    end
  endtask

  task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned quota);
    int unsigned stop_at;
    send_idle_pct  = idle_pct;
    recv_stall_pct <= stall_pct;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) send_frame();
    wait_for_results();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-byte zero markers, comma separator, empty field included
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h41);
    send_byte(8'd44);
    send_byte(8'd44);
    send_byte(8'h00);
    send_tick();
    wait_for_results();

    // Four-byte markers, oversized start length, all-ones separator
    set_cfg(32'hDEADBEEF, 32'd7, 32'h0D0A0D0A, 32'd4, 32'hFF, 32'hFFFF, 32'hFFFF);
    send_byte(8'hDE);
    send_byte(8'hAD);
    send_byte(8'hBE);
    send_byte(8'hEF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h11);
    send_byte(8'h0D);
    send_byte(8'h0A);
    send_byte(8'h0D);
    send_byte(8'h0A);
    send_byte(8'hDE);
    send_byte(8'hAD);
    send_byte(8'hBE);
    send_byte(8'hEF);
    send_byte(8'h41);
    send_byte(8'h42);
    wait_for_results();

    // End marker shrinks inside an open frame; held bytes go with the marker
    write_reg(REG_END_LENGTH, 32'd1);
    send_byte(8'h43);
    send_byte(8'h0A);
    wait_for_results();

    // Random frames over several settings and idling mixes
    set_cfg($urandom, 32'd2, $urandom, 32'd2, 8'($urandom), 32'd100, 32'd2500);
    run_phase(0, 0, 16);
    set_cfg($urandom, 32'd0, $urandom, 32'd0, 32'h00, 32'd0, 32'hFFFF);
    run_phase(71, 0, 16);
    set_cfg($urandom, 32'd4, $urandom, 32'd3, 8'($urandom), 32'hFFFF, 32'd5);
    run_phase(0, 71, 16);
    set_cfg($urandom, 32'd1, $urandom, 32'd0, 32'h2C, 32'd3, 32'd0);
    run_phase(26, 26, 16);
    set_cfg(32'hFFFFFFFF, 32'd3, 32'h00000000, 32'd5, 32'hFF, 32'd2, 32'd20);
    run_phase(71, 0, 16);
    set_cfg($urandom, 32'd6, $urandom, 32'd1, 8'($urandom), 32'd1, 32'd40);
    run_phase(0, 71, 16);

    repeat (16) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mfs_pkg.sv
hw/rtl/mfs_parser.sv
hw/rtl/mfs_result_queue.sv
hw/rtl/marker_framed_field_splitter_unit.sv
tb/sv/marker_framed_field_splitter_unit_tb.sv
